/* rtl/assert_macros.svh */
// Assertion macros shared by the cursor tracker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
// The module must have i_clk and i_rst_n in scope.
`define PMCT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pmct_pkg.sv */
// Package with types, constants and register map of the mouse cursor tracker.
package pmct_pkg;

    // Cursor coordinate storage width.
    localparam int COORD_BITS = 16;
    // Working width for position arithmetic and clamping.
    localparam int CALC_W = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
    localparam logic signed [CALC_W-1:0] CRD_HI =
        CALC_W'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
    localparam logic signed [CALC_W-1:0] CRD_LO = -CRD_HI - CALC_W'(1);

    // Movement deltas: 9-bit signed packet values, negated for Y.
    localparam int DELTA_W = 10;
    localparam int MAG_W   = 9;
    localparam int Q_W     = 10;

    // Division by five: multiply by ceil(2^16/5) and shift right by 16.
    // Exact for every magnitude up to the largest delta times sensitivity.
    localparam int RECIP_SHIFT = 16;
    localparam int DIV5_RECIP  = 13108;
    localparam int SCALE_W     = 18;

    // Saturating accumulators.
    localparam int ACC_W = 32;
    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // Configuration port.
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;
    localparam int SENS_MIN = 1;
    localparam int SENS_MAX = 10;
    localparam int SENS_RST = 7;
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(SENS_RST * DIV5_RECIP);
    localparam logic signed [15:0] MIN_X_RST = 16'sd0;
    localparam logic signed [15:0] MIN_Y_RST = 16'sd0;
    localparam logic signed [15:0] MAX_X_RST = 16'sd1919;
    localparam logic signed [15:0] MAX_Y_RST = 16'sd1079;

    // Cursor reset position.
    localparam int POS_X_RST = 960;
    localparam int POS_Y_RST = 540;

    // Bits of the first PS/2 packet byte.
    localparam int FLAG_SYNC_BIT  = 3;
    localparam int FLAG_XSIGN_BIT = 4;
    localparam int FLAG_YSIGN_BIT = 5;

    typedef enum logic [2:0] {
        REG_SENS   = 3'd0,
        REG_WHEEL  = 3'd1,
        REG_MIN_X  = 3'd2,
        REG_MIN_Y  = 3'd3,
        REG_MAX_X  = 3'd4,
        REG_MAX_Y  = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        K_PS2   = 2'd0,
        K_HID   = 2'd1,
        K_SET   = 2'd2,
        K_CLEAR = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        AX_HOLD,
        AX_MOVE,
        AX_SET,
        AX_CLEAR
    } t_axis_op;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data_byte;
        logic signed [7:0]  hid_dx;
        logic signed [7:0]  hid_dy;
        logic [7:0]         hid_buttons;
        logic signed [7:0]  hid_wheel;
        logic signed [15:0] new_x;
        logic signed [15:0] new_y;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] cursor_x;
        logic signed [15:0] cursor_y;
        logic [2:0]         buttons_now;
        logic [2:0]         buttons_before;
        logic signed [31:0] sum_dx;
        logic signed [31:0] sum_dy;
        logic signed [7:0]  scroll_value;
        logic               updated;
        logic               byte_dropped;
    } t_out_item;

    // Register values seen by the datapath.
    typedef struct packed {
        logic [SCALE_W-1:0] scale;
        logic               wheel;
        logic signed [15:0] min_x;
        logic signed [15:0] min_y;
        logic signed [15:0] max_x;
        logic signed [15:0] max_y;
    } t_cfg;

    // Per-axis command from the packet decoder.
    typedef struct packed {
        t_axis_op                  op;
        logic signed [DELTA_W-1:0] delta;
        logic signed [15:0]        new_pos;
    } t_axis_ctl;

    // Status of one processed item.
    typedef struct packed {
        logic updated;
        logic dropped;
    } t_item_flags;

endpackage

/* rtl/pmct_if.sv */
// Valid/ready channel interfaces for input items and result items.
interface pmct_in_if;
    logic                valid;
    logic                ready;
    pmct_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pmct_out_if;
    logic                valid;
    logic                ready;
    pmct_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pmct_regs.sv */
// APB configuration registers of the cursor tracker.
module pmct_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [pmct_pkg::PADDR_W-1:0] i_paddr,
    input  logic [pmct_pkg::PDATA_W-1:0] i_pwdata,
    output logic [pmct_pkg::PDATA_W-1:0] o_prdata,
    output logic                         o_pready,
    output pmct_pkg::t_cfg               o_cfg
);

    logic [3:0]           r_sens;
    logic [3:0]           n_sens;
    pmct_pkg::t_cfg       r_cfg;
    pmct_pkg::t_reg_idx   reg_idx;
    logic                 wr_en;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign reg_idx  = pmct_pkg::t_reg_idx'(i_paddr[4:2]);

    // Sensitivity is saturated into its legal range on write.
    always_comb begin
        n_sens = i_pwdata[3:0];
        if (n_sens < 4'(pmct_pkg::SENS_MIN)) begin
            n_sens = 4'(pmct_pkg::SENS_MIN);
        end else if (n_sens > 4'(pmct_pkg::SENS_MAX)) begin
            n_sens = 4'(pmct_pkg::SENS_MAX);
        end
    end

    // Register writes; the scale factor is precomputed from sensitivity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sens      <= 4'(pmct_pkg::SENS_RST);
            r_cfg.scale <= pmct_pkg::SCALE_RST;
            r_cfg.wheel <= 1'b0;
            r_cfg.min_x <= pmct_pkg::MIN_X_RST;
            r_cfg.min_y <= pmct_pkg::MIN_Y_RST;
            r_cfg.max_x <= pmct_pkg::MAX_X_RST;
            r_cfg.max_y <= pmct_pkg::MAX_Y_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                pmct_pkg::REG_SENS: begin
                    r_sens      <= n_sens;
                    r_cfg.scale <= pmct_pkg::SCALE_W'(n_sens) *
                                   pmct_pkg::SCALE_W'(pmct_pkg::DIV5_RECIP);
                end
                pmct_pkg::REG_WHEEL: r_cfg.wheel <= i_pwdata[0];
                pmct_pkg::REG_MIN_X: r_cfg.min_x <= i_pwdata[15:0];
                pmct_pkg::REG_MIN_Y: r_cfg.min_y <= i_pwdata[15:0];
                pmct_pkg::REG_MAX_X: r_cfg.max_x <= i_pwdata[15:0];
                pmct_pkg::REG_MAX_Y: r_cfg.max_y <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_idx)
            pmct_pkg::REG_SENS:  o_prdata = pmct_pkg::PDATA_W'(r_sens);
            pmct_pkg::REG_WHEEL: o_prdata = pmct_pkg::PDATA_W'(r_cfg.wheel);
            pmct_pkg::REG_MIN_X: o_prdata = pmct_pkg::PDATA_W'(r_cfg.min_x);
            pmct_pkg::REG_MIN_Y: o_prdata = pmct_pkg::PDATA_W'(r_cfg.min_y);
            pmct_pkg::REG_MAX_X: o_prdata = pmct_pkg::PDATA_W'(r_cfg.max_x);
            pmct_pkg::REG_MAX_Y: o_prdata = pmct_pkg::PDATA_W'(r_cfg.max_y);
            default:             o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/pmct_axis.sv */
// One cursor axis: scaled move, bounds clamp and saturating movement sum.
module pmct_axis (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_step,
    input  pmct_pkg::t_axis_ctl                    i_ctl,
    input  logic [pmct_pkg::SCALE_W-1:0]           i_scale,
    input  logic signed [15:0]                     i_min,
    input  logic signed [15:0]                     i_max,
    input  logic signed [pmct_pkg::COORD_BITS-1:0] i_pos_rst,
    output logic signed [pmct_pkg::COORD_BITS-1:0] o_pos,
    output logic signed [pmct_pkg::ACC_W-1:0]      o_sum
);

    localparam int PROD_W = pmct_pkg::MAG_W + pmct_pkg::SCALE_W;
    localparam int CW     = pmct_pkg::CALC_W;

    logic signed [pmct_pkg::COORD_BITS-1:0] r_pos;
    logic signed [pmct_pkg::COORD_BITS-1:0] n_pos;
    logic signed [pmct_pkg::ACC_W-1:0]      r_acc;
    logic signed [pmct_pkg::ACC_W-1:0]      n_acc;
    logic [pmct_pkg::DELTA_W-1:0]           abs_d;
    logic [PROD_W-1:0]                      prod;
    logic [pmct_pkg::Q_W-1:0]               quot;
    logic signed [CW-1:0]                   step_mag;
    logic signed [CW-1:0]                   step_val;
    logic signed [CW-1:0]                   target;
    logic signed [CW-1:0]                   lo;
    logic signed [CW-1:0]                   hi;
    logic signed [pmct_pkg::ACC_W:0]        sum_wide;

    // Scaled delta, truncated toward zero: work on the magnitude.
    assign abs_d    = i_ctl.delta[pmct_pkg::DELTA_W-1] ? -i_ctl.delta : i_ctl.delta;
    assign prod     = PROD_W'(abs_d[pmct_pkg::MAG_W-1:0]) * PROD_W'(i_scale);
    assign quot     = prod[pmct_pkg::RECIP_SHIFT +: pmct_pkg::Q_W];
    assign step_mag = $signed(CW'(quot));
    assign step_val = i_ctl.delta[pmct_pkg::DELTA_W-1] ? -step_mag : step_mag;

    // New position, min clamp first, then max clamp, then storage range.
    assign lo = CW'(i_min);
    assign hi = CW'(i_max);
    always_comb begin
        if (i_ctl.op == pmct_pkg::AX_SET) begin
            target = CW'(i_ctl.new_pos);
        end else begin
            target = CW'(r_pos) + step_val;
        end
        if (target < lo) begin
            target = lo;
        end
        if (target > hi) begin
            target = hi;
        end
        if (target < pmct_pkg::CRD_LO) begin
            target = pmct_pkg::CRD_LO;
        end else if (target > pmct_pkg::CRD_HI) begin
            target = pmct_pkg::CRD_HI;
        end
        n_pos = pmct_pkg::COORD_BITS'(target);
    end

    // Saturating accumulation of the raw delta.
    assign sum_wide = (pmct_pkg::ACC_W+1)'(r_acc) + (pmct_pkg::ACC_W+1)'(i_ctl.delta);
    always_comb begin
        if (sum_wide[pmct_pkg::ACC_W] != sum_wide[pmct_pkg::ACC_W-1]) begin
            n_acc = sum_wide[pmct_pkg::ACC_W] ? pmct_pkg::ACC_MIN : pmct_pkg::ACC_MAX;
        end else begin
            n_acc = sum_wide[pmct_pkg::ACC_W-1:0];
        end
    end

    // Axis state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= i_pos_rst;
            r_acc <= '0;
        end else if (i_step) begin
            case (i_ctl.op)
                pmct_pkg::AX_MOVE: begin
                    r_pos <= n_pos;
                    r_acc <= n_acc;
                end
                pmct_pkg::AX_SET:   r_pos <= n_pos;
                pmct_pkg::AX_CLEAR: r_acc <= '0;
                default: ;
            endcase
        end
    end

    assign o_pos = r_pos;
    assign o_sum = r_acc;

endmodule

/* rtl/pmct_packet.sv */
// PS/2 packet assembly, item decoding, buttons and scroll state.
`include "assert_macros.svh"

module pmct_packet (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  pmct_pkg::t_in_item        i_item,
    input  logic                      i_wheel,
    output pmct_pkg::t_axis_ctl       o_ctl_x,
    output pmct_pkg::t_axis_ctl       o_ctl_y,
    output pmct_pkg::t_item_flags     o_flags,
    output logic [2:0]                o_buttons_now,
    output logic [2:0]                o_buttons_before,
    output logic signed [7:0]         o_scroll
);

    localparam int DW = pmct_pkg::DELTA_W;

    logic [1:0]           r_idx;
    logic [7:0]           r_bytes [3];
    logic [2:0]           r_btn;
    logic [2:0]           r_prev;
    logic signed [7:0]    r_scroll;

    logic                 drop;
    logic                 done;
    logic [7:0]           b0;
    logic [7:0]           b1;
    logic [7:0]           b2;
    logic signed [DW-1:0] pkt_dx;
    logic signed [DW-1:0] pkt_dy_raw;

    // Packet framing: resync on a first byte without the sync bit.
    assign drop = (r_idx == 2'd0) && !i_item.data_byte[pmct_pkg::FLAG_SYNC_BIT];
    assign done = i_wheel ? (r_idx == 2'd3) : (r_idx >= 2'd2);

    // Packet bytes as seen with the current byte merged in.
    assign b0 = (r_idx == 2'd0) ? i_item.data_byte : r_bytes[0];
    assign b1 = (r_idx == 2'd1) ? i_item.data_byte : r_bytes[1];
    assign b2 = (r_idx == 2'd2) ? i_item.data_byte : r_bytes[2];
    assign pkt_dx     = DW'($signed({b0[pmct_pkg::FLAG_XSIGN_BIT], b1}));
    assign pkt_dy_raw = DW'($signed({b0[pmct_pkg::FLAG_YSIGN_BIT], b2}));

    // Per-item axis commands and status.
    always_comb begin
        o_ctl_x.op      = pmct_pkg::AX_HOLD;
        o_ctl_x.delta   = '0;
        o_ctl_x.new_pos = i_item.new_x;
        o_ctl_y.op      = pmct_pkg::AX_HOLD;
        o_ctl_y.delta   = '0;
        o_ctl_y.new_pos = i_item.new_y;
        o_flags         = '0;
        unique case (i_item.kind)
            pmct_pkg::K_PS2: begin
                if (drop) begin
                    o_flags.dropped = 1'b1;
                end else if (done) begin
                    o_ctl_x.op      = pmct_pkg::AX_MOVE;
                    o_ctl_x.delta   = pkt_dx;
                    o_ctl_y.op      = pmct_pkg::AX_MOVE;
                    o_ctl_y.delta   = -pkt_dy_raw;
                    o_flags.updated = 1'b1;
                end
            end
            pmct_pkg::K_HID: begin
                o_ctl_x.op      = pmct_pkg::AX_MOVE;
                o_ctl_x.delta   = DW'(i_item.hid_dx);
                o_ctl_y.op      = pmct_pkg::AX_MOVE;
                o_ctl_y.delta   = DW'(i_item.hid_dy);
                o_flags.updated = 1'b1;
            end
            pmct_pkg::K_SET: begin
                o_ctl_x.op = pmct_pkg::AX_SET;
                o_ctl_y.op = pmct_pkg::AX_SET;
            end
            pmct_pkg::K_CLEAR: begin
                o_ctl_x.op = pmct_pkg::AX_CLEAR;
                o_ctl_y.op = pmct_pkg::AX_CLEAR;
            end
            default: ;
        endcase
    end

    // Packet byte store; only written, so it needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_step && (i_item.kind == pmct_pkg::K_PS2) && !drop && (r_idx != 2'd3)) begin
            r_bytes[r_idx] <= i_item.data_byte;
        end
    end

    // Byte counter, buttons and scroll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_btn    <= '0;
            r_prev   <= '0;
            r_scroll <= '0;
        end else if (i_step) begin
            case (i_item.kind)
                pmct_pkg::K_PS2: begin
                    if (!drop) begin
                        if (done) begin
                            r_idx    <= '0;
                            r_prev   <= r_btn;
                            r_btn    <= b0[2:0];
                            r_scroll <= i_wheel ? $signed(i_item.data_byte) : 8'sd0;
                        end else begin
                            r_idx <= r_idx + 2'd1;
                        end
                    end
                end
                pmct_pkg::K_HID: begin
                    r_prev   <= r_btn;
                    r_btn    <= i_item.hid_buttons[2:0];
                    r_scroll <= i_item.hid_wheel;
                end
                pmct_pkg::K_CLEAR: r_scroll <= '0;
                default: ;
            endcase
        end
    end

    assign o_buttons_now    = r_btn;
    assign o_buttons_before = r_prev;
    assign o_scroll         = r_scroll;

    // A byte is only discarded while waiting for the first byte of a packet.
    `PMCT_ASSERT_NOW(a_drop_only_at_start,
        i_step && (i_item.kind == pmct_pkg::K_PS2) && (r_idx != 2'd0), !o_flags.dropped,
        "byte dropped in the middle of a packet")
    // A discarded byte leaves packet assembly at its first byte.
    `PMCT_ASSERT_NEXT(a_drop_keeps_idx, i_step && o_flags.dropped, r_idx == 2'd0,
        "byte counter moved on a discarded byte")

endmodule

/* rtl/ps2_mouse_packet_cursor_tracker_unit.sv */
// Top level of the PS/2 mouse packet decoder and cursor tracker.
// Usage:
//   i_item carries one transaction per input item: a PS/2 byte, a HID report,
//   an absolute position, or an accumulator clear, selected by kind.
//   o_result returns exactly one transaction per input item with the cursor
//   position, buttons, movement sums and scroll value after that item.
//   Registers are written through the APB port (4-byte stride); the user
//   must write them only while idle, which the block does not enforce.
// Timing:
//   An accepted item is held in an input register, then decoded and applied
//   to the tracker state as it leaves that register; its result is offered
//   in the following cycle. One item is accepted per cycle while no result
//   waits or o_result.ready is high, so the sustained rate is one item per clock.
// Reset:
//   Synchronous active-low reset empties both stages, puts the cursor at
//   (960, 540), clears buttons, sums, scroll and packet framing, and restores
//   register defaults.
// Stall:
//   While a result waits, the input register still takes one more item; then
//   i_item.ready falls until o_result.ready takes the pending result.
`include "assert_macros.svh"

module ps2_mouse_packet_cursor_tracker_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    pmct_in_if.sink                      i_item,
    pmct_out_if.source                   o_result,
    input  logic                         i_psel,
    input  logic                         i_penable,
    input  logic                         i_pwrite,
    input  logic [pmct_pkg::PADDR_W-1:0] i_paddr,
    input  logic [pmct_pkg::PDATA_W-1:0] i_pwdata,
    output logic [pmct_pkg::PDATA_W-1:0] o_prdata,
    output logic                         o_pready
);

    logic                                   r_in_vld;
    pmct_pkg::t_in_item                     r_in;
    logic                                   r_out_vld;
    pmct_pkg::t_item_flags                  r_flags;
    logic                                   advance;

    pmct_pkg::t_cfg                         cfg;
    pmct_pkg::t_axis_ctl                    ctl_x;
    pmct_pkg::t_axis_ctl                    ctl_y;
    pmct_pkg::t_item_flags                  flags;
    logic [2:0]                             btn_now;
    logic [2:0]                             btn_before;
    logic signed [7:0]                      scroll;
    logic signed [pmct_pkg::COORD_BITS-1:0] pos_x;
    logic signed [pmct_pkg::COORD_BITS-1:0] pos_y;
    logic signed [pmct_pkg::ACC_W-1:0]      sum_x;
    logic signed [pmct_pkg::ACC_W-1:0]      sum_y;
    pmct_pkg::t_out_item                    result;

    // The tracker state doubles as the result register: it only changes
    // when no result is pending or the pending result is being taken.
    assign advance        = r_in_vld && (!r_out_vld || o_result.ready);
    assign i_item.ready   = !r_in_vld || advance;

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_in_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in <= i_item.data;
        end
    end

    // Result stage valid and per-item status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_flags   <= '0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
            r_flags   <= flags;
        end else if (o_result.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    pmct_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    pmct_packet u_packet (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (advance),
        .i_item           (r_in),
        .i_wheel          (cfg.wheel),
        .o_ctl_x          (ctl_x),
        .o_ctl_y          (ctl_y),
        .o_flags          (flags),
        .o_buttons_now    (btn_now),
        .o_buttons_before (btn_before),
        .o_scroll         (scroll)
    );

    pmct_axis u_axis_x (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_ctl     (ctl_x),
        .i_scale   (cfg.scale),
        .i_min     (cfg.min_x),
        .i_max     (cfg.max_x),
        .i_pos_rst (pmct_pkg::COORD_BITS'(pmct_pkg::POS_X_RST)),
        .o_pos     (pos_x),
        .o_sum     (sum_x)
    );

    pmct_axis u_axis_y (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_ctl     (ctl_y),
        .i_scale   (cfg.scale),
        .i_min     (cfg.min_y),
        .i_max     (cfg.max_y),
        .i_pos_rst (pmct_pkg::COORD_BITS'(pmct_pkg::POS_Y_RST)),
        .o_pos     (pos_y),
        .o_sum     (sum_y)
    );

    // Result payload.
    always_comb begin
        result.cursor_x       = 16'(pos_x);
        result.cursor_y       = 16'(pos_y);
        result.buttons_now    = btn_now;
        result.buttons_before = btn_before;
        result.sum_dx         = sum_x;
        result.sum_dy         = sum_y;
        result.scroll_value   = scroll;
        result.updated        = r_flags.updated;
        result.byte_dropped   = r_flags.dropped;
    end

    assign o_result.valid = r_out_vld;
    assign o_result.data  = result;

    // An item is never both applied and discarded.
    `PMCT_ASSERT_NOW(a_flags_exclusive, r_out_vld, !(r_flags.updated && r_flags.dropped),
        "result both updated and dropped")
    // Every item that leaves the input stage produces a result.
    `PMCT_ASSERT_NEXT(a_advance_gives_result, advance, r_out_vld,
        "processed item produced no result")
    // A held input item is not lost.
    `PMCT_ASSERT_NEXT(a_input_held, r_in_vld && !advance, r_in_vld,
        "stalled input item was lost")

endmodule

/* bench/tb_ps2_mouse_packet_cursor_tracker_unit.sv */
// Self-checking testbench for the PS/2 mouse packet cursor tracker.
module tb_ps2_mouse_packet_cursor_tracker_unit;
    import pmct_pkg::*;

    localparam int REPORT_LIMIT = 10;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_COUNT = 12;
    localparam int PHASE_ITEMS = 150;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_psel = 1'b0;
    logic                 i_penable = 1'b0;
    logic                 i_pwrite = 1'b0;
    logic [PADDR_W-1:0]   i_paddr = '0;
    logic [PDATA_W-1:0]   i_pwdata = '0;
    logic [PDATA_W-1:0]   o_prdata;
    logic                 o_pready;

    pmct_in_if  item_if();
    pmct_out_if result_if();

    ps2_mouse_packet_cursor_tracker_unit i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (item_if),
        .o_result  (result_if),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready)
    );

    // Predicted register settings.
    longint     cfg_sens;
    bit         cfg_wheel;
    longint     cfg_min_x, cfg_min_y, cfg_max_x, cfg_max_y;

    // Predicted tracker state.
    int unsigned       frame_pos;
    logic [7:0]        frame_bytes [3];
    longint            cur_x, cur_y;
    logic [2:0]        btn_now, btn_prev;
    longint            sum_x, sum_y;
    logic signed [7:0] scroll_now;

    // Cursor reports still owed by the block, oldest first.
    t_out_item expected_reports [$];

    int  mismatch_count = 0;
    int  reports_checked = 0;
    int  kind_count [4] = '{0, 0, 0, 0};
    int  drops_seen = 0;
    int  packets_seen = 0;
    int  config_writes = 0;
    bit  steady_mode = 1'b0;
    int  hold_requests = 0;
    int  hold_length = 0;

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog for a hung handshake.
    initial begin
        #5_000_000;
        $display("ps2_mouse_packet_cursor_tracker_unit test failed");
        $finish;
    end

    // Mostly short gaps, with the occasional long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic longint saturate(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Bounds clamp with min first, so max wins on inverted bounds, then the
    // coordinate width limit.
    function automatic longint clamp_position(longint v, longint lo, longint hi);
        longint lim;
        lim = longint'(1) << (COORD_BITS - 1);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        return saturate(v, -lim, lim - 1);
    endfunction

    function automatic void reset_tracker_model();
        cfg_sens = SENS_RST;
        cfg_wheel = 1'b0;
        cfg_min_x = MIN_X_RST;
        cfg_min_y = MIN_Y_RST;
        cfg_max_x = MAX_X_RST;
        cfg_max_y = MAX_Y_RST;
        frame_pos = 0;
        frame_bytes = '{8'h00, 8'h00, 8'h00};
        cur_x = POS_X_RST;
        cur_y = POS_Y_RST;
        btn_now = '0;
        btn_prev = '0;
        sum_x = 0;
        sum_y = 0;
        scroll_now = '0;
    endfunction

    // Raw deltas go into the sums; scaled deltas move the cursor.
    function automatic void apply_motion(longint dx, longint dy);
        sum_x = saturate(sum_x + dx, ACC_MIN, ACC_MAX);
        sum_y = saturate(sum_y + dy, ACC_MIN, ACC_MAX);
        cur_x = clamp_position(cur_x + (dx * cfg_sens) / 5, cfg_min_x, cfg_max_x);
        cur_y = clamp_position(cur_y + (dy * cfg_sens) / 5, cfg_min_y, cfg_max_y);
    endfunction

    // Works out the cursor report that one input transaction produces.
    function automatic t_out_item predict_cursor(t_in_item it);
        t_out_item   r;
        longint      dx, dy;
        int unsigned frame_len;
        logic [7:0]  flags;
        logic        upd, drop;
        upd = 1'b0;
        drop = 1'b0;
        case (it.kind)
            K_PS2: begin
                if (frame_pos == 0 && !it.data_byte[FLAG_SYNC_BIT]) begin
                    drop = 1'b1;
                end else begin
                    frame_len = cfg_wheel ? 4 : 3;
                    if (frame_pos < 3) frame_bytes[frame_pos] = it.data_byte;
                    if (frame_pos + 1 >= frame_len) begin
                        flags = frame_bytes[0];
                        dx = longint'(frame_bytes[1]);
                        dy = longint'(frame_bytes[2]);
                        if (flags[FLAG_XSIGN_BIT]) dx -= 256;
                        if (flags[FLAG_YSIGN_BIT]) dy -= 256;
                        dy = -dy;
                        btn_prev = btn_now;
                        btn_now = flags[2:0];
                        apply_motion(dx, dy);
                        scroll_now = cfg_wheel ? it.data_byte : 8'sd0;
                        frame_pos = 0;
                        upd = 1'b1;
                    end else begin
                        frame_pos = (frame_pos + 1) % 4;
                    end
                end
            end
            K_HID: begin
                btn_prev = btn_now;
                btn_now = it.hid_buttons[2:0];
                apply_motion(longint'($signed(it.hid_dx)), longint'($signed(it.hid_dy)));
                scroll_now = it.hid_wheel;
                upd = 1'b1;
            end
            K_SET: begin
                cur_x = clamp_position(longint'($signed(it.new_x)), cfg_min_x, cfg_max_x);
                cur_y = clamp_position(longint'($signed(it.new_y)), cfg_min_y, cfg_max_y);
            end
            default: begin
                sum_x = 0;
                sum_y = 0;
                scroll_now = '0;
            end
        endcase
        r.cursor_x = cur_x[15:0];
        r.cursor_y = cur_y[15:0];
        r.buttons_now = btn_now;
        r.buttons_before = btn_prev;
        r.sum_dx = sum_x[31:0];
        r.sum_dy = sum_y[31:0];
        r.scroll_value = scroll_now;
        r.updated = upd;
        r.byte_dropped = drop;
        return r;
    endfunction

    function automatic string differing_fields(t_out_item want, t_out_item got);
        string s;
        s = "";
        if (got.cursor_x !== want.cursor_x) s = {s, " cursor_x"};
        if (got.cursor_y !== want.cursor_y) s = {s, " cursor_y"};
        if (got.buttons_now !== want.buttons_now) s = {s, " buttons_now"};
        if (got.buttons_before !== want.buttons_before) s = {s, " buttons_before"};
        if (got.sum_dx !== want.sum_dx) s = {s, " sum_dx"};
        if (got.sum_dy !== want.sum_dy) s = {s, " sum_dy"};
        if (got.scroll_value !== want.scroll_value) s = {s, " scroll_value"};
        if (got.updated !== want.updated) s = {s, " updated"};
        if (got.byte_dropped !== want.byte_dropped) s = {s, " byte_dropped"};
        return s;
    endfunction

    function automatic void report_mismatch(string what, t_out_item want, t_out_item got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("MISMATCH (%0s): expected %p, got %p", what, want, got);
    endfunction

    // Compare every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_item want;
        string     diffs;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_reports.size() == 0) begin
                report_mismatch("result with nothing expected", '0, result_if.data);
            end else begin
                want = expected_reports.pop_front();
                diffs = differing_fields(want, result_if.data);
                reports_checked++;
                if (diffs != "") report_mismatch({"fields", diffs}, want, result_if.data);
            end
        end
    end

    // Result side: random stalls, plus long hold-offs on request.
    initial begin
        int stall_left;
        int hold_left;
        int hold_seen;
        stall_left = 0;
        hold_left = 0;
        hold_seen = 0;
        result_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_requests) begin
                hold_seen = hold_requests;
                hold_left = hold_length;
            end
            if (hold_left > 0) begin
                result_if.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                result_if.ready <= 1'b0;
                stall_left--;
            end else begin
                result_if.ready <= 1'b1;
                if (!steady_mode && $urandom_range(0, 99) < 25) stall_left = pick_gap();
            end
        end
    end

    // Offer one item and wait for its transaction; valid stays high after.
    task automatic send_item(input t_in_item it);
        int        gap;
        t_out_item want;
        gap = steady_mode ? 0 : pick_gap();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        item_if.valid <= 1'b1;
        item_if.data <= it;
        do @(posedge i_clk); while (!item_if.ready);
        want = predict_cursor(it);
        expected_reports.push_back(want);
        kind_count[int'(it.kind)]++;
        if (want.byte_dropped) drops_seen++;
        if (want.updated && it.kind == K_PS2) packets_seen++;
    endtask

    // Stop sending and let every owed result come back.
    task automatic wait_for_results();
        item_if.valid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write through the APB port; only called while idle.
    task automatic write_reg(input t_reg_idx idx, input logic [15:0] value);
        logic [31:0] word;
        int          s;
        word = {16'($urandom), value};
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= PADDR_W'({idx, 2'b00});
        i_pwdata <= word;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (idx)
            REG_SENS: begin
                s = int'(word[3:0]);
                if (s < SENS_MIN) s = SENS_MIN;
                if (s > SENS_MAX) s = SENS_MAX;
                cfg_sens = s;
            end
            REG_WHEEL: cfg_wheel = word[0];
            REG_MIN_X: cfg_min_x = longint'($signed(word[15:0]));
            REG_MIN_Y: cfg_min_y = longint'($signed(word[15:0]));
            REG_MAX_X: cfg_max_x = longint'($signed(word[15:0]));
            default:   cfg_max_y = longint'($signed(word[15:0]));
        endcase
        config_writes++;
        @(posedge i_clk);
    endtask

    task automatic write_bounds(input int lo_x, input int hi_x, input int lo_y, input int hi_y);
        write_reg(REG_MIN_X, 16'(lo_x));
        write_reg(REG_MAX_X, 16'(hi_x));
        write_reg(REG_MIN_Y, 16'(lo_y));
        write_reg(REG_MAX_Y, 16'(hi_y));
    endtask

    // Every field random, so the unused fields toggle too.
    function automatic t_in_item random_fields();
        t_in_item it;
        it.kind = t_kind'($urandom_range(0, 3));
        it.data_byte = 8'($urandom);
        it.hid_dx = 8'($urandom);
        it.hid_dy = 8'($urandom);
        it.hid_buttons = 8'($urandom);
        it.hid_wheel = 8'($urandom);
        it.new_x = 16'($urandom);
        it.new_y = 16'($urandom);
        return it;
    endfunction

    task automatic ps2_byte(input logic [7:0] b);
        t_in_item it;
        it = random_fields();
        it.kind = K_PS2;
        it.data_byte = b;
        send_item(it);
    endtask

    task automatic hid_report(input int dx, input int dy, input logic [7:0] btn, input int whl);
        t_in_item it;
        it = random_fields();
        it.kind = K_HID;
        it.hid_dx = 8'(dx);
        it.hid_dy = 8'(dy);
        it.hid_buttons = btn;
        it.hid_wheel = 8'(whl);
        send_item(it);
    endtask

    task automatic set_position(input int x, input int y);
        t_in_item it;
        it = random_fields();
        it.kind = K_SET;
        it.new_x = 16'(x);
        it.new_y = 16'(y);
        send_item(it);
    endtask

    task automatic clear_sums();
        t_in_item it;
        it = random_fields();
        it.kind = K_CLEAR;
        send_item(it);
    endtask

    // Resync drop, the largest deltas of both signs, HID extremes, set and clear.
    task automatic test_packet_extremes();
        ps2_byte(8'h00);
        ps2_byte(8'h3F);
        ps2_byte(8'h00);
        ps2_byte(8'h00);
        ps2_byte(8'h0F);
        ps2_byte(8'hFF);
        ps2_byte(8'hFF);
        hid_report(127, -128, 8'hFF, -128);
        hid_report(-128, 127, 8'h00, 127);
        set_position(32767, -32768);
        clear_sums();
        set_position(-32768, 32767);
    endtask

    // Sensitivity saturation on write and truncation toward zero.
    task automatic test_sensitivity_limits();
        logic [15:0] sens_values [3];
        sens_values = '{16'd0, 16'd15, 16'd3};
        wait_for_results();
        write_bounds(-32768, 32767, -32768, 32767);
        foreach (sens_values[i]) begin
            wait_for_results();
            write_reg(REG_SENS, sens_values[i]);
            hid_report(-128, 127, 8'h05, 1);
            hid_report(-3, 4, 8'h02, -1);
        end
    endtask

    // Inverted bounds: the max bound wins.
    task automatic test_bounds();
        wait_for_results();
        write_bounds(32767, -32768, 100, 50);
        set_position(0, 0);
        hid_report(10, -10, 8'h01, 0);
        wait_for_results();
        write_bounds(MIN_X_RST, MAX_X_RST, MIN_Y_RST, MAX_Y_RST);
    endtask

    // Wheel mode changed while a packet is only partly assembled.
    task automatic test_wheel_switch();
        wait_for_results();
        write_reg(REG_WHEEL, 16'd1);
        ps2_byte(8'h08);
        ps2_byte(8'h01);
        ps2_byte(8'h02);
        wait_for_results();
        write_reg(REG_WHEEL, 16'd0);
        ps2_byte(8'h55);
        ps2_byte(8'h28);
        ps2_byte(8'h05);
        wait_for_results();
        write_reg(REG_WHEEL, 16'd1);
        ps2_byte(8'h06);
        ps2_byte(8'h80);
    endtask

    // The receiver holds off long enough for the input side to back up.
    task automatic test_backpressure();
        wait_for_results();
        hold_length = 400;
        hold_requests++;
        steady_mode = 1'b1;
        repeat (40) send_item(random_fields());
        steady_mode = 1'b0;
        wait_for_results();
    endtask

    task automatic randomize_config(input int phase);
        int lo_x, lo_y;
        write_reg(REG_SENS, 16'($urandom));
        write_reg(REG_WHEEL, 16'($urandom));
        case (phase % 4)
            0: write_bounds(MIN_X_RST, MAX_X_RST, MIN_Y_RST, MAX_Y_RST);
            1: write_bounds(-32768, 32767, -32768, 32767);
            2: begin
                lo_x = int'($urandom_range(0, 4000)) - 2000;
                lo_y = int'($urandom_range(0, 4000)) - 2000;
                write_bounds(lo_x, lo_x + int'($urandom_range(0, 3000)),
                             lo_y, lo_y + int'($urandom_range(0, 3000)));
            end
            default: write_bounds($urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    // Mostly whole packets with random content, mixed with noise bytes,
    // HID reports, absolute positions and clears.
    task automatic run_random_phase(input int count);
        t_in_item it;
        int       sent;
        int       r;
        int       len;
        sent = 0;
        while (sent < count) begin
            r = $urandom_range(0, 99);
            it = random_fields();
            if (r < 55) begin
                len = cfg_wheel ? 4 : 3;
                for (int b = 0; b < len; b++) begin
                    it = random_fields();
                    it.kind = K_PS2;
                    if (b == 0) it.data_byte[FLAG_SYNC_BIT] = 1'b1;
                    send_item(it);
                end
                sent += len;
            end else begin
                if (r < 65) it.kind = K_PS2;
                else if (r < 83) it.kind = K_HID;
                else if (r < 93) it.kind = K_SET;
                else it.kind = K_CLEAR;
                send_item(it);
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_for_results();
            randomize_config(p);
            steady_mode = (p == 5);
            run_random_phase(PHASE_ITEMS);
        end
        steady_mode = 1'b0;
    endtask

    // Test sequence.
    initial begin
        item_if.valid <= 1'b0;
        item_if.data <= '0;
        reset_tracker_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_packet_extremes();
        test_sensitivity_limits();
        test_bounds();
        test_wheel_switch();
        test_backpressure();
        test_random_traffic();
        wait_for_results();
        $display("Checked %0d results: %0d PS/2 bytes (%0d packets, %0d dropped), %0d HID reports,",
                 reports_checked, kind_count[0], packets_seen, drops_seen, kind_count[1]);
        $display("%0d position sets, %0d clears, %0d register writes; %0d mismatches.",
                 kind_count[2], kind_count[3], config_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("ps2_mouse_packet_cursor_tracker_unit test passed");
        end else begin
            $display("ps2_mouse_packet_cursor_tracker_unit test failed");
        end
        $finish;
    end

endmodule
